// ===== rtl/mvcc_pkg.sv =====
// Shared types and codes for the transaction status table.
// Holds request/response item layouts, record word layout and request codes.
// No dependencies.
package mvcc_pkg;

   localparam logic [2:0] REQ_START       = 3'd0;
   localparam logic [2:0] REQ_COMMIT      = 3'd1;
   localparam logic [2:0] REQ_ABORT       = 3'd2;
   localparam logic [2:0] REQ_READ_CHECK  = 3'd3;
   localparam logic [2:0] REQ_WRITE_CHECK = 3'd4;

   localparam logic [1:0] REC_NONE      = 2'd0;
   localparam logic [1:0] REC_RUNNING   = 2'd1;
   localparam logic [1:0] REC_COMMITTED = 2'd2;
   localparam logic [1:0] REC_ABORTED   = 2'd3;

   localparam logic [1:0] ERR_OK        = 2'd0;
   localparam logic [1:0] ERR_NOT_LIVE  = 2'd1;
   localparam logic [1:0] ERR_EXHAUSTED = 2'd2;

   localparam logic [31:0] MIN_TRID   = 32'd1;
   localparam logic [31:0] MIN_COMMIT = 32'd1;
   localparam logic [31:0] ID_NONE    = 32'hFFFF_FFFF;
   localparam logic [31:0] COUNT_TOP  = 32'hFFFF_FFFF;

   typedef struct packed {
      logic [2:0]  req_type;
      logic [31:0] self_id;
      logic [31:0] target_id;
      logic        target_is_xmax;
   } req_item_type;

   typedef struct packed {
      logic [31:0] issued_id;
      logic        verdict;
      logic [1:0]  error_code;
   } rsp_item_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] end_count;
   } stat_word_type;

endpackage

// ===== rtl/mvcc_slot_calc.sv =====
// Ring slot of a transaction id: id modulo the ring depth. Depends on nothing.
// Power-of-two depths take the low bits; other depths multiply by a fixed
// reciprocal and correct once through id, quotient, difference and remainder registers.
module mvcc_slot_calc #(
   parameter int RING_DEPTH = 256,
   parameter int AW         = 8
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          load,
   input  logic [31:0]   id,
   output logic [AW-1:0] slot,
   output logic          done
);

   generate
      if ((RING_DEPTH & (RING_DEPTH - 1)) == 0) begin : g_pow2
         logic unused_ctl;
         assign unused_ctl = clock ^ reset ^ load;
         assign slot = id[AW-1:0];
         assign done = 1'b1 | unused_ctl;
      end else begin : g_div
         localparam logic [31:0] RECIP    = 32'((64'd1 << 32) / RING_DEPTH);
         localparam logic [31:0] DEPTH_32 = 32'(RING_DEPTH);
         localparam logic [AW:0] DEPTH_W  = (AW+1)'(RING_DEPTH);
         logic [31:0]   id_ff, id_in;
         logic [31:0]   quot_ff, quot_in;
         logic [AW:0]   diff_ff, diff_in;
         logic [AW-1:0] rem_ff, rem_in;
         logic [1:0]    cnt_ff, cnt_in;
         logic          done_ff, done_in;
         logic [63:0]   product;
         logic [31:0]   multiple;

         always_comb begin
            id_in    = load ? id : id_ff;
            product  = 64'(id_ff) * 64'(RECIP);
            quot_in  = product[63:32];
            multiple = quot_ff * DEPTH_32;
            diff_in  = (AW+1)'(id_ff - multiple);
            rem_in   = (diff_ff >= DEPTH_W) ? AW'(diff_ff - DEPTH_W) : AW'(diff_ff);
            cnt_in   = cnt_ff;
            done_in  = done_ff;
            if (load) begin
               cnt_in  = '0;
               done_in = 1'b0;
            end else if (!done_ff) begin
               cnt_in  = cnt_ff + 2'd1;
               done_in = (cnt_ff == 2'd2);
            end
         end

         always_ff @(posedge clock) begin
            id_ff   <= id_in;
            quot_ff <= quot_in;
            diff_ff <= diff_in;
            rem_ff  <= rem_in;
            if (reset) begin
               cnt_ff  <= '0;
               done_ff <= 1'b0;
            end else begin
               cnt_ff  <= cnt_in;
               done_ff <= done_in;
            end
         end

         assign slot = rem_ff;
         assign done = done_ff & ~load;
      end
   endgenerate

endmodule

// ===== rtl/mvcc_ring.sv =====
// Transaction record ring: begin-count memory and status/end-count memory.
// One registered read of each per cycle, one write of each per cycle.
// Depends on mvcc_pkg.
module mvcc_ring
   import mvcc_pkg::*;
#(
   parameter int RING_DEPTH = 256,
   parameter int AW         = 8
) (
   input  logic          clock,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_begin_addr,
   input  logic [AW-1:0] rd_stat_addr,
   output logic [31:0]   rd_begin,
   output stat_word_type rd_stat,
   input  logic          wr_begin_en,
   input  logic [AW-1:0] wr_begin_addr,
   input  logic [31:0]   wr_begin_data,
   input  logic          wr_stat_en,
   input  logic [AW-1:0] wr_stat_addr,
   input  stat_word_type wr_stat_data
);

   logic [31:0]   begin_mem [RING_DEPTH];
   stat_word_type stat_mem  [RING_DEPTH];
   logic [31:0]   rd_begin_ff;
   stat_word_type rd_stat_ff;

   always_ff @(posedge clock) begin
      if (wr_begin_en) begin
         begin_mem[wr_begin_addr] <= wr_begin_data;
      end
      if (rd_en) begin
         rd_begin_ff <= begin_mem[rd_begin_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_stat_en) begin
         stat_mem[wr_stat_addr] <= wr_stat_data;
      end
      if (rd_en) begin
         rd_stat_ff <= stat_mem[rd_stat_addr];
      end
   end

   assign rd_begin = rd_begin_ff;
   assign rd_stat  = rd_stat_ff;

endmodule

// ===== rtl/mvcc_transaction_status_table.sv =====
// Transaction status table top level: request control, id/commit counters
// and snapshot visibility checks. Depends on mvcc_pkg, mvcc_slot_calc, mvcc_ring.
//
//   channel   | handshake                 | payload
//   ----------+---------------------------+---------------
//   request   | start && !busy            | req_item
//   response  | rsp_valid (one cycle)     | rsp_item
//
// With a power-of-two RING_DEPTH a request reads memory at acceptance and
// evaluates and writes back in the next cycle. Other depths first wait in
// ST_WAIT for the reciprocal slot calculation. Response appears the cycle after
// evaluation, one per request, and cannot be stalled by the receiver.
// Reset clears the counters and control; ring records stay undefined until written.
module mvcc_transaction_status_table
   import mvcc_pkg::*;
#(
   parameter int RING_DEPTH = 256
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  req_item_type req_item,
   output logic         busy,
   output logic         rsp_valid,
   output rsp_item_type rsp_item
);

   localparam int AW = (RING_DEPTH > 2) ? $clog2(RING_DEPTH) : 1;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_WAIT = 2'd1;
   localparam logic [1:0] ST_EXEC = 2'd2;

   logic [1:0]    state_ff, state_in;
   req_item_type  req_ff, req_in;
   logic [31:0]   a_id_ff, a_id_in;
   logic [31:0]   b_id_ff, b_id_in;
   logic [31:0]   next_id_ff, next_id_in;
   logic [31:0]   oldest_ff, oldest_in;
   logic [31:0]   commit_ff, commit_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_item_type  rsp_ff, rsp_in;

   logic          accept;
   logic          load;
   logic [AW-1:0] slot_a, slot_b;
   logic          done_a, done_b;
   logic          rd_en;
   logic [31:0]   rd_begin;
   stat_word_type rd_stat;
   logic          wr_begin_en, wr_stat_en;
   logic [31:0]   wr_begin_data;
   stat_word_type wr_stat_data;
   logic          self_live;
   logic [31:0]   snap_begin;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;
   assign load   = accept;

   always_comb begin
      if (state_ff == ST_IDLE) begin
         a_id_in = (req_item.req_type == REQ_START) ? next_id_ff : req_item.self_id;
         b_id_in = req_item.target_id;
      end else begin
         a_id_in = a_id_ff;
         b_id_in = b_id_ff;
      end
   end

   mvcc_slot_calc #(.RING_DEPTH(RING_DEPTH), .AW(AW)) u_slot_a (
      .clock (clock),
      .reset (reset),
      .load  (load),
      .id    (a_id_in),
      .slot  (slot_a),
      .done  (done_a)
   );

   mvcc_slot_calc #(.RING_DEPTH(RING_DEPTH), .AW(AW)) u_slot_b (
      .clock (clock),
      .reset (reset),
      .load  (load),
      .id    (b_id_in),
      .slot  (slot_b),
      .done  (done_b)
   );

   mvcc_ring #(.RING_DEPTH(RING_DEPTH), .AW(AW)) u_ring (
      .clock         (clock),
      .rd_en         (rd_en),
      .rd_begin_addr (slot_a),
      .rd_stat_addr  (slot_b),
      .rd_begin      (rd_begin),
      .rd_stat       (rd_stat),
      .wr_begin_en   (wr_begin_en),
      .wr_begin_addr (slot_a),
      .wr_begin_data (wr_begin_data),
      .wr_stat_en    (wr_stat_en),
      .wr_stat_addr  (slot_a),
      .wr_stat_data  (wr_stat_data)
   );

   assign self_live = (req_ff.self_id >= oldest_ff) && (req_ff.self_id < next_id_ff);
   assign snap_begin = (next_id_ff > req_ff.self_id) ? rd_begin : COUNT_TOP;

   always_comb begin
      state_in      = state_ff;
      req_in        = req_ff;
      next_id_in    = next_id_ff;
      oldest_in     = oldest_ff;
      commit_in     = commit_ff;
      rsp_valid_in  = 1'b0;
      rsp_in        = rsp_ff;
      rd_en         = 1'b0;
      wr_begin_en   = 1'b0;
      wr_stat_en    = 1'b0;
      wr_begin_data = commit_ff;
      wr_stat_data  = '{status: REC_NONE, end_count: 32'd0};

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               req_in = req_item;
               if (done_a && done_b) begin
                  rd_en    = 1'b1;
                  state_in = ST_EXEC;
               end else begin
                  state_in = ST_WAIT;
               end
            end
         end
         ST_WAIT: begin
            if (done_a && done_b) begin
               rd_en    = 1'b1;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in     = ST_IDLE;
            rsp_valid_in = 1'b1;
            rsp_in       = '{issued_id: 32'd0, verdict: 1'b0, error_code: ERR_OK};
            case (req_ff.req_type) inside
               REQ_START: begin
                  if (next_id_ff == ID_NONE) begin
                     rsp_in.error_code = ERR_EXHAUSTED;
                  end else begin
                     rsp_in.issued_id = next_id_ff;
                     next_id_in       = next_id_ff + 32'd1;
                     wr_begin_en      = 1'b1;
                     wr_stat_en       = 1'b1;
                     wr_stat_data     = '{status: REC_RUNNING, end_count: 32'd0};
                  end
               end
               REQ_COMMIT, REQ_ABORT: begin
                  if (!self_live) begin
                     rsp_in.error_code = ERR_NOT_LIVE;
                  end else begin
                     wr_stat_en = 1'b1;
                     if (req_ff.req_type == REQ_COMMIT) begin
                        wr_stat_data = '{status: REC_COMMITTED, end_count: commit_ff};
                        commit_in    = commit_ff + 32'd1;
                     end else begin
                        wr_stat_data = '{status: REC_ABORTED, end_count: 32'd0};
                     end
                  end
               end
               REQ_READ_CHECK: begin
                  if (req_ff.target_id == req_ff.self_id) begin
                     rsp_in.verdict = 1'b1;
                  end else if (req_ff.target_id < oldest_ff) begin
                     rsp_in.verdict = 1'b1;
                  end else if (next_id_ff <= req_ff.target_id) begin
                     rsp_in.verdict = 1'b0;
                  end else if ((next_id_ff > req_ff.self_id) &&
                               (req_ff.self_id < oldest_ff)) begin
                     rsp_in.error_code = ERR_NOT_LIVE;
                  end else begin
                     rsp_in.verdict = (rd_stat.status == REC_COMMITTED) &&
                                      (rd_stat.end_count < snap_begin);
                  end
               end
               REQ_WRITE_CHECK: begin
                  if ((req_ff.self_id == ID_NONE) || (req_ff.target_id == ID_NONE)) begin
                     rsp_in.verdict = 1'b0;
                  end else if (req_ff.target_id == req_ff.self_id) begin
                     rsp_in.verdict = 1'b0;
                  end else if (req_ff.target_id < oldest_ff) begin
                     rsp_in.verdict = req_ff.target_is_xmax;
                  end else if (next_id_ff <= req_ff.target_id) begin
                     rsp_in.verdict = 1'b0;
                  end else begin
                     rsp_in.verdict = (rd_stat.status == REC_RUNNING) ||
                                      ((rd_stat.status == REC_COMMITTED) &&
                                       req_ff.target_is_xmax);
                  end
               end
               default: begin
                  rsp_in.verdict = 1'b0;
               end
            endcase
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      req_ff  <= req_in;
      a_id_ff <= a_id_in;
      b_id_ff <= b_id_in;
      rsp_ff  <= rsp_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         next_id_ff   <= MIN_TRID;
         oldest_ff    <= MIN_TRID;
         commit_ff    <= MIN_COMMIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         next_id_ff   <= next_id_in;
         oldest_ff    <= oldest_in;
         commit_ff    <= commit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule
